// File: hdl/read_clip_point_merge_defines.svh
// Assertion macros shared by the checker of the read clip point merge block.
`ifndef READ_CLIP_POINT_MERGE_DEFINES_SVH
`define READ_CLIP_POINT_MERGE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RCPM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RCPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rcpm_pkg.sv
// Shared widths, register indexes, types and helpers of the read clip point merge block.
`timescale 1ns / 1ps

package rcpm_pkg;

	localparam int POS_W        = 12;
	localparam int MAX_POSITION = 4095;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_ENABLE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUALITY_ENABLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLYAT_ENABLE  = 2'd2;

	typedef logic [POS_W-1:0] pos_t;

	// One read record as it arrives.
	typedef struct packed {
		pos_t read_length;
		logic rmid_found;
		pos_t right_tag_start;
		pos_t left_tag_end;
		pos_t adapter_pos;
		pos_t quality_left;
		pos_t quality_right;
		pos_t vector_start;
		pos_t vector_end;
		pos_t tail_clip;
		pos_t head_clip;
		logic discard_in;
	} read_rec_t;

	// One merged result.
	typedef struct packed {
		pos_t left_clip;
		pos_t right_clip;
		logic discard_out;
		logic left_by_quality;
		logic left_by_adapter;
		logic left_by_vector;
		logic left_by_polyat;
		logic right_by_quality;
		logic right_by_adapter;
		logic right_by_vector;
		logic right_by_polyat;
	} clip_res_t;

	// Clamp a position to the largest legal position.
	function automatic pos_t sat_pos(input pos_t x);
		logic [16:0] wide;
		wide = {{(17-POS_W){1'b0}}, x};
		if (wide > 17'(MAX_POSITION))
			return POS_W'(MAX_POSITION);
		return x;
	endfunction

	function automatic pos_t pos_min(input pos_t a, input pos_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pos_t pos_max(input pos_t a, input pos_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: hdl/read_clip_point_merge.sv
// Top level of the read clip point merge block: input register, merge logic, result register.
`timescale 1ns / 1ps

// An accepted input beat passes through the input register and then the result register
// before its result beat appears on out_valid.
// Throughput: one read per cycle; the block takes a new beat every cycle the result
// side does not stall, and a full result register only holds the input side when
// the input register is occupied as well.
// Reset (arst_n low) empties both pipeline stages and clears the three enables to 0.
module read_clip_point_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port.
	input  logic                                 cfg_we,
	input  logic [rcpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rcpm_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rcpm_pkg::POS_W-1:0]           read_length,
	input  logic                                 rmid_found,
	input  logic [rcpm_pkg::POS_W-1:0]           right_tag_start,
	input  logic [rcpm_pkg::POS_W-1:0]           left_tag_end,
	input  logic [rcpm_pkg::POS_W-1:0]           adapter_pos,
	input  logic [rcpm_pkg::POS_W-1:0]           quality_left,
	input  logic [rcpm_pkg::POS_W-1:0]           quality_right,
	input  logic [rcpm_pkg::POS_W-1:0]           vector_start,
	input  logic [rcpm_pkg::POS_W-1:0]           vector_end,
	input  logic [rcpm_pkg::POS_W-1:0]           tail_clip,
	input  logic [rcpm_pkg::POS_W-1:0]           head_clip,
	input  logic                                 discard_in,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [rcpm_pkg::POS_W-1:0]           left_clip,
	output logic [rcpm_pkg::POS_W-1:0]           right_clip,
	output logic                                 discard_out,
	output logic                                 left_by_quality,
	output logic                                 left_by_adapter,
	output logic                                 left_by_vector,
	output logic                                 left_by_polyat,
	output logic                                 right_by_quality,
	output logic                                 right_by_adapter,
	output logic                                 right_by_vector,
	output logic                                 right_by_polyat
);

	// Configuration registers. The user must change them only while the block is idle; the block
	// does not enforce this, so the merge logic reads them directly.
	logic vector_enable_q;
	logic quality_enable_q;
	logic polyat_enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_enable_q  <= 1'b0;
			quality_enable_q <= 1'b0;
			polyat_enable_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcpm_pkg::CFG_VECTOR_ENABLE:  vector_enable_q  <= cfg_data[0];
				rcpm_pkg::CFG_QUALITY_ENABLE: quality_enable_q <= cfg_data[0];
				rcpm_pkg::CFG_POLYAT_ENABLE:  polyat_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control. Each stage loads when it is empty or when the stage after
	// it hands its beat on in the same cycle, so a full pipeline still moves one
	// beat per cycle while out_stall is low.
	logic                valid_s1;
	logic                valid_s2;
	logic                adv_s1;
	logic                adv_s2;
	rcpm_pkg::read_rec_t rec_s1;
	rcpm_pkg::clip_res_t res_s2;
	rcpm_pkg::clip_res_t res_d;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers carry no reset; the valid bits above qualify them.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			rec_s1.read_length     <= read_length;
			rec_s1.rmid_found      <= rmid_found;
			rec_s1.right_tag_start <= right_tag_start;
			rec_s1.left_tag_end    <= left_tag_end;
			rec_s1.adapter_pos     <= adapter_pos;
			rec_s1.quality_left    <= quality_left;
			rec_s1.quality_right   <= quality_right;
			rec_s1.vector_start    <= vector_start;
			rec_s1.vector_end      <= vector_end;
			rec_s1.tail_clip       <= tail_clip;
			rec_s1.head_clip       <= head_clip;
			rec_s1.discard_in      <= discard_in;
		end
		if (adv_s2 && valid_s1)
			res_s2 <= res_d;
	end

	// Merge logic. A missing right tag or B adapter (position 0) stands for the read length
	// when the minimum is taken, but cause matching still compares against the raw position.
	// Each mode sets the right cause flags in a fixed order of precedence, so a right tie
	// credits only the first of them; with the vector enable on, a left tie credits all.
	always_comb begin
		rcpm_pkg::pos_t len;
		rcpm_pkg::pos_t rs;
		rcpm_pkg::pos_t lm;
		rcpm_pkg::pos_t ad;
		rcpm_pkg::pos_t ql;
		rcpm_pkg::pos_t qr;
		rcpm_pkg::pos_t vs;
		rcpm_pkg::pos_t ve;
		rcpm_pkg::pos_t pa;
		rcpm_pkg::pos_t pt;
		rcpm_pkg::pos_t rsv;
		rcpm_pkg::pos_t adv;
		rcpm_pkg::pos_t lc;
		rcpm_pkg::pos_t rc;
		logic [rcpm_pkg::POS_W:0] vsum;
		logic vright;
		logic disc;
		logic lq, la, lv, lp, rq, ra, rv, rp;

		len = rcpm_pkg::sat_pos(rec_s1.read_length);
		rs  = rec_s1.rmid_found ? rcpm_pkg::sat_pos(rec_s1.right_tag_start) : '0;
		lm  = rcpm_pkg::sat_pos(rec_s1.left_tag_end);
		ad  = rcpm_pkg::sat_pos(rec_s1.adapter_pos);
		ql  = rcpm_pkg::sat_pos(rec_s1.quality_left);
		qr  = rcpm_pkg::sat_pos(rec_s1.quality_right);
		vs  = rcpm_pkg::sat_pos(rec_s1.vector_start);
		ve  = rcpm_pkg::sat_pos(rec_s1.vector_end);
		pa  = rcpm_pkg::sat_pos(rec_s1.tail_clip);
		pt  = rcpm_pkg::sat_pos(rec_s1.head_clip);

		rsv  = (rs == '0) ? len : rs;
		adv  = (ad == '0) ? len : ad;
		// The vector lies on the right when its midpoint is at or past the middle
		// of the read.
		vsum   = {1'b0, vs} + {1'b0, ve};
		vright = vsum >= {1'b0, len};

		disc = rec_s1.discard_in;
		lc   = rcpm_pkg::POS_W'(1);
		rc   = rcpm_pkg::POS_W'(1);
		lq = 1'b0; la = 1'b0; lv = 1'b0; lp = 1'b0;
		rq = 1'b0; ra = 1'b0; rv = 1'b0; rp = 1'b0;

		if (!disc) begin
			if (vector_enable_q && quality_enable_q) begin
				if (vright) begin
					rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv),
						rcpm_pkg::pos_min(qr, vs));
					if (rc == qr)      rq = 1'b1;
					else if (rc == rs) ra = 1'b1;
					else if (rc == vs) rv = 1'b1;
					else if (rc == ad) ra = 1'b1;
					lc = rcpm_pkg::pos_max(ql, lm);
					lq = (lc == ql);
					la = (lc == lm);
				end else begin
					rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv), qr);
					if (rc == qr)      rq = 1'b1;
					else if (rc == rs) ra = 1'b1;
					else if (rc == ad) ra = 1'b1;
					lc = rcpm_pkg::pos_max(rcpm_pkg::pos_max(ql, lm), ve);
					lq = (lc == ql);
					lv = (lc == ve);
					la = (lc == lm);
				end
			end else if (vector_enable_q) begin
				if (vright) begin
					rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv), vs);
					if (rc == rs)      ra = 1'b1;
					else if (rc == vs) rv = 1'b1;
					else if (rc == ad) ra = 1'b1;
					lc = lm;
					la = (lm != '0);
				end else begin
					rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv), len);
					if (rc == rs)      ra = 1'b1;
					else if (rc == ad) ra = 1'b1;
					lc = rcpm_pkg::pos_max(lm, ve);
					lv = (lc == ve);
					la = (lc == lm);
				end
			end else if (quality_enable_q) begin
				rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv), qr);
				if (rc == rs)      ra = 1'b1;
				else if (rc == ad) ra = 1'b1;
				else               rq = 1'b1;
				lc = rcpm_pkg::pos_max(ql, lm);
				if (lc == ql) lq = 1'b1;
				else          la = 1'b1;
				// A clip at the read end is no adapter trim.
				if (rc == len) ra = 1'b0;
			end else begin
				rc = rcpm_pkg::pos_min(rcpm_pkg::pos_min(rsv, adv), len);
				if (rc == rs)      ra = 1'b1;
				else if (rc == ad) ra = 1'b1;
				lc = lm;
				la = (lm != '0);
				if (rc == len) ra = 1'b0;
			end

			if (rc <= rcpm_pkg::POS_W'(1))
				disc = 1'b1;

			// Poly-A/T override: a tighter tail or head clip replaces the merged clip and
			// takes the credit from the first matching earlier cause. The discard
			// decision is not revisited.
			if (polyat_enable_q && !disc) begin
				if (rc > pa && pa != '0) begin
					if (rc == ad)      ra = 1'b0;
					else if (rc == rs) ra = 1'b0;
					else if (rc == qr) rq = 1'b0;
					else if (rc == vs) rv = 1'b0;
					rc = pa;
					rp = 1'b1;
				end
				if (lc < pt && pt != '0) begin
					if (lc == lm)      la = 1'b0;
					else if (lc == ql) lq = 1'b0;
					else if (lc == ve) lv = 1'b0;
					lc = pt;
					lp = 1'b1;
				end
			end
		end

		res_d.left_clip        = lc;
		res_d.right_clip       = rc;
		res_d.discard_out      = disc;
		res_d.left_by_quality  = lq;
		res_d.left_by_adapter  = la;
		res_d.left_by_vector   = lv;
		res_d.left_by_polyat   = lp;
		res_d.right_by_quality = rq;
		res_d.right_by_adapter = ra;
		res_d.right_by_vector  = rv;
		res_d.right_by_polyat  = rp;
	end

	assign out_valid        = valid_s2;
	assign left_clip        = res_s2.left_clip;
	assign right_clip       = res_s2.right_clip;
	assign discard_out      = res_s2.discard_out;
	assign left_by_quality  = res_s2.left_by_quality;
	assign left_by_adapter  = res_s2.left_by_adapter;
	assign left_by_vector   = res_s2.left_by_vector;
	assign left_by_polyat   = res_s2.left_by_polyat;
	assign right_by_quality = res_s2.right_by_quality;
	assign right_by_adapter = res_s2.right_by_adapter;
	assign right_by_vector  = res_s2.right_by_vector;
	assign right_by_polyat  = res_s2.right_by_polyat;

endmodule

// File: hdl/rcpm_checker.sv
// Port-level assertion checker for the read clip point merge block, with its bind.
`timescale 1ns / 1ps
`include "read_clip_point_merge_defines.svh"

module rcpm_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [rcpm_pkg::POS_W-1:0]           left_clip,
	input logic [rcpm_pkg::POS_W-1:0]           right_clip,
	input logic                                 discard_out,
	input logic                                 left_by_polyat,
	input logic                                 right_by_polyat
);

	// A stalled result beat holds.
	`RCPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(right_clip) && $stable(left_clip) && $stable(discard_out), "result beat changed while stalled")

	// A discarded read never ends with a right clip past 1 and never gets a tail override.
	`RCPM_ASSERT_NOW(a_discard_clip, out_valid && discard_out, right_clip <= rcpm_pkg::POS_W'(1) && !left_by_polyat && !right_by_polyat, "discarded read has a bad clip or tail flag")

	// A tail override always lands on a real, nonzero position.
	`RCPM_ASSERT_NOW(a_polyat_nonzero, out_valid && (left_by_polyat || right_by_polyat), (!left_by_polyat || left_clip != '0) && (!right_by_polyat || right_clip != '0), "tail override at position zero")

	// If the result side is free once the beat is in the input register, an accepted beat passes on to out_valid.
	`RCPM_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid, "accepted beat did not reach the output in two cycles")

endmodule

bind read_clip_point_merge rcpm_checker u_rcpm_checker (.*);
